// ----- src/ebtg_pkg.sv -----
// Shared types, constants and the sine table function for the beep tone generator.
// No dependencies.
package ebtg_pkg;

  localparam int FREQ_BITS     = 15;
  localparam int MS_BITS       = 16;
  localparam int RATE_BITS     = 16;
  localparam int VOL_BITS      = 16;
  localparam int FADE_BITS     = 12;
  localparam int SAMPLE_BITS   = 16;
  localparam int SINE_MAG_BITS = 15;
  localparam int LEN_PROD_BITS = MS_BITS + RATE_BITS;
  localparam int MUL1_BITS     = SINE_MAG_BITS + VOL_BITS;
  localparam int MUL2_BITS     = MUL1_BITS + FADE_BITS;
  localparam int GAIN_Q_BITS   = MUL2_BITS - VOL_BITS;
  localparam int MIN_BITS      = FADE_BITS + 2;

  // floor(x / 1000) == (x * MS_RECIP) >> LEN_SHIFT for every 32-bit x
  localparam int RECIP_BITS    = 29;
  localparam int LEN_MUL_BITS  = LEN_PROD_BITS + RECIP_BITS;
  localparam int LEN_SHIFT     = 38;

  localparam logic [RECIP_BITS-1:0] MS_RECIP    = 29'd274877907;
  localparam logic [MIN_BITS-1:0]   MIN_EXTRA   = 14'd10;
  localparam logic [63:0]           HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]           Q30_ONE     = 64'd1 << 30;

  typedef enum logic [1:0] {
    CFG_SAMPLE_RATE  = 2'd0,
    CFG_VOLUME       = 2'd1,
    CFG_FADE_IN_LEN  = 2'd2,
    CFG_FADE_OUT_LEN = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_STEP,
    DIV_GAIN
  } div_sel_t;

  typedef struct packed {
    logic [RATE_BITS-1:0] sample_rate;
    logic [VOL_BITS-1:0]  volume;
    logic [FADE_BITS-1:0] fade_in_len;
    logic [FADE_BITS-1:0] fade_out_len;
  } cfg_t;

  typedef struct packed {
    logic                 command;
    logic [FREQ_BITS-1:0] tone_freq;
    logic [MS_BITS-1:0]   duration_ms;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          active;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul1;
    logic     mul2;
    logic     step_wr;
    logic     beep_wr;
    logic     tick_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic is_beep;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

  // sin(x), x in [0, pi/2], unsigned Q30 in and out
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  // table entry k of a 2^tb entry table, Q1.15 clamped to +-32767
  function automatic logic signed [SAMPLE_BITS-1:0] sine_entry(input int unsigned k,
                                                               input int unsigned tb);
    logic [63:0] quarter;
    logic [63:0] quad;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] s;
    quarter = 64'd1 << (tb - 2);
    quad    = (64'(k) >> (tb - 2)) & 64'd3;
    q       = 64'(k) & (quarter - 64'd1);
    if (quad[0]) begin
      q = quarter - q;
    end
    x = (HALF_PI_Q30 * q) >> (tb - 2);
    s = (quarter_sine_q30(x) + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return quad[1] ? SAMPLE_BITS'(64'd0 - s) : SAMPLE_BITS'(s);
  endfunction

endpackage

// ----- src/ebtg_div.sv -----
// Restoring divider, one quotient bit per cycle, for the beep tone generator.
// Depends on nothing; numerator is left aligned, iters gives the bits to process.
module ebtg_div #(
  parameter int NW = 47,
  parameter int DW = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NW-1:0]            numer,
  input  logic [DW-1:0]            denom,
  input  logic [$clog2(NW+1)-1:0]  iters,
  output logic                     done,
  output logic [NW-1:0]            quot
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, quot[NW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= iters;
      rem  <= '0;
      dvs  <= denom;
      quot <= numer;
    end else if (busy) begin
      rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quot <= {quot[NW-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ----- src/ebtg_datapath.sv -----
// Datapath: tone state, sine ROM, gain multipliers, shared divider and output register.
// Depends on ebtg_pkg and ebtg_div.
module ebtg_datapath #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32,
  parameter int COUNT_BITS      = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  ebtg_pkg::cfg_t     cfg,
  input  ebtg_pkg::in_t      in_data,
  input  ebtg_pkg::dp_cmd_t  cmd,
  output ebtg_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output ebtg_pkg::out_t     out_data
);

  localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
  localparam int STEP_NW    = PHASE_BITS + ebtg_pkg::FREQ_BITS;
  localparam int DIV_NW     = (STEP_NW > ebtg_pkg::GAIN_Q_BITS) ? STEP_NW
                                                                 : ebtg_pkg::GAIN_Q_BITS;
  localparam int DIV_CW     = $clog2(DIV_NW + 1);
  localparam int SB         = ebtg_pkg::SAMPLE_BITS;
  localparam int GQ         = ebtg_pkg::GAIN_Q_BITS;
  localparam int FB         = ebtg_pkg::FADE_BITS;
  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

  ebtg_pkg::in_t              item;
  logic [PHASE_BITS-1:0]      phase_acc;
  logic [PHASE_BITS-1:0]      phase_step;
  logic [COUNT_BITS-1:0]      total_samples;
  logic [COUNT_BITS-1:0]      sample_index;
  logic                       playing;
  logic signed [SB-1:0]       sine_q;
  logic                       neg;
  logic                       live;
  logic [FB-1:0]              num;
  logic [FB-1:0]              den;
  logic [ebtg_pkg::MUL1_BITS-1:0] prod1;
  logic [ebtg_pkg::MUL2_BITS-1:0] prod2;

  logic signed [SB-1:0] sine_rom [TABLE_SIZE];

  for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
    assign sine_rom[k] = ebtg_pkg::sine_entry(k, SINE_TABLE_BITS);
  end

  always_ff @(posedge clk) begin
    sine_q <= sine_rom[phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS]];
  end

  // gain selection
  logic                  live_c;
  logic [COUNT_BITS-1:0] remain;
  logic [FB-1:0]         num_c;
  logic [FB-1:0]         den_c;
  logic [SB-1:0]         sine_abs;

  assign live_c   = playing && (sample_index < total_samples);
  assign remain   = total_samples - sample_index;
  assign sine_abs = sine_q[SB-1] ? SB'(16'd0 - sine_q) : sine_q;

  always_comb begin
    priority if (sample_index < COUNT_BITS'(cfg.fade_in_len)) begin
      num_c = sample_index[FB-1:0];
      den_c = cfg.fade_in_len;
    end else if (remain < COUNT_BITS'(cfg.fade_out_len)) begin
      num_c = remain[FB-1:0];
      den_c = cfg.fade_out_len;
    end else begin
      num_c = FB'(1);
      den_c = FB'(1);
    end
  end

  // shared divider
  logic [DIV_NW-1:0]                 div_numer;
  logic [ebtg_pkg::RATE_BITS-1:0]    div_denom;
  logic [DIV_CW-1:0]                 div_iters;
  logic                              div_done;
  logic [DIV_NW-1:0]                 div_quot;

  always_comb begin
    unique case (cmd.div_sel)
      ebtg_pkg::DIV_STEP: begin
        div_numer = DIV_NW'({item.tone_freq, {PHASE_BITS{1'b0}}}) << (DIV_NW - STEP_NW);
        div_denom = cfg.sample_rate;
        div_iters = DIV_CW'(STEP_NW);
      end
      default: begin
        div_numer = DIV_NW'(prod2[ebtg_pkg::MUL2_BITS-1:ebtg_pkg::VOL_BITS]) << (DIV_NW - GQ);
        div_denom = ebtg_pkg::RATE_BITS'(den);
        div_iters = DIV_CW'(GQ);
      end
    endcase
  end

  ebtg_div #(
    .NW (DIV_NW),
    .DW (ebtg_pkg::RATE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (div_numer),
    .denom (div_denom),
    .iters (div_iters),
    .done  (div_done),
    .quot  (div_quot)
  );

  // beep length: ms * rate / 1000 by reciprocal multiply, then minimum and saturation
  logic [ebtg_pkg::LEN_PROD_BITS-1:0] len_prod;
  logic [ebtg_pkg::LEN_PROD_BITS-1:0] len_prod_q;
  logic [ebtg_pkg::LEN_MUL_BITS-1:0]  len_mul;
  logic [ebtg_pkg::MIN_BITS-1:0]      min_len;
  logic [31:0]                        len_q;
  logic [31:0]                        len_min;
  logic [31:0]                        len_sat;

  assign len_prod = ebtg_pkg::LEN_PROD_BITS'(item.duration_ms)
                  * ebtg_pkg::LEN_PROD_BITS'(cfg.sample_rate);
  assign len_mul  = ebtg_pkg::LEN_MUL_BITS'(len_prod_q)
                  * ebtg_pkg::LEN_MUL_BITS'(ebtg_pkg::MS_RECIP);

  always_ff @(posedge clk) begin
    len_prod_q <= len_prod;
    len_q      <= 32'(len_mul[ebtg_pkg::LEN_MUL_BITS-1:ebtg_pkg::LEN_SHIFT]);
  end

  assign min_len = ebtg_pkg::MIN_BITS'(cfg.fade_in_len) + ebtg_pkg::MIN_BITS'(cfg.fade_out_len)
                 + ebtg_pkg::MIN_EXTRA;
  assign len_min = (len_q < 32'(min_len)) ? 32'(min_len) : len_q;
  assign len_sat = (len_min > CNT_MAX) ? CNT_MAX : len_min;

  // tick result
  logic [GQ-1:0]         mag;
  logic [SB-1:0]         mag_neg;
  logic signed [SB-1:0]  amp;
  logic [COUNT_BITS-1:0] index_after;
  logic                  playing_after;

  assign mag     = div_quot[GQ-1:0];
  assign mag_neg = 16'd0 - mag[SB-1:0];

  always_comb begin
    priority if (!live) begin
      amp = '0;
    end else if (neg) begin
      amp = (mag > GQ'(32768)) ? 16'sh8000 : mag_neg;
    end else begin
      amp = (mag > GQ'(32767)) ? 16'sh7fff : mag[SB-1:0];
    end
  end

  assign index_after   = live ? sample_index + 1'b1 : sample_index;
  assign playing_after = playing
                      && !((total_samples != '0) && (index_after >= total_samples));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc     <= '0;
      phase_step    <= '0;
      total_samples <= '0;
      sample_index  <= '0;
      playing       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.step_wr) begin
        phase_step <= (cfg.sample_rate == '0) ? '0 : div_quot[PHASE_BITS-1:0];
      end
      if (cmd.beep_wr) begin
        total_samples <= len_sat[COUNT_BITS-1:0];
        if (!playing) begin
          phase_acc    <= '0;
          sample_index <= '0;
          playing      <= 1'b1;
        end else begin
          sample_index <= COUNT_BITS'(cfg.fade_in_len);
        end
      end
      if (cmd.tick_wr) begin
        if (live) begin
          phase_acc <= phase_acc + phase_step;
        end
        sample_index <= index_after;
        playing      <= playing_after;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.mul1) begin
      prod1 <= ebtg_pkg::MUL1_BITS'(sine_abs[ebtg_pkg::SINE_MAG_BITS-1:0])
             * ebtg_pkg::MUL1_BITS'(cfg.volume);
      neg   <= sine_q[SB-1];
      live  <= live_c;
      num   <= num_c;
      den   <= den_c;
    end
    if (cmd.mul2) begin
      prod2 <= ebtg_pkg::MUL2_BITS'(prod1) * ebtg_pkg::MUL2_BITS'(num);
    end
    if (cmd.tick_wr) begin
      out_data.sample <= amp;
      out_data.active <= playing_after;
    end
  end

  assign stat.is_beep  = item.command;
  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid && !out_ready;

endmodule

// ----- src/ebtg_ctrl.sv -----
// Controller state machine sequencing beep and tick beats through the datapath.
// Depends on ebtg_pkg.
module ebtg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ebtg_pkg::dp_stat_t stat,
  output ebtg_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_STEP_DIV,
    S_STEP_WAIT,
    S_BEEP_DONE,
    S_MUL1,
    S_MUL2,
    S_GAIN_DIV,
    S_GAIN_WAIT,
    S_TICK_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DISPATCH;
        end
        S_DISPATCH:  state <= stat.is_beep ? S_STEP_DIV : S_MUL1;
        S_STEP_DIV:  state <= S_STEP_WAIT;
        S_STEP_WAIT: begin
          if (stat.div_done) state <= S_BEEP_DONE;
        end
        S_BEEP_DONE: state <= S_IDLE;
        S_MUL1:      state <= S_MUL2;
        S_MUL2:      state <= S_GAIN_DIV;
        S_GAIN_DIV:  state <= S_GAIN_WAIT;
        S_GAIN_WAIT: begin
          if (stat.div_done) state <= S_TICK_DONE;
        end
        S_TICK_DONE: begin
          if (!stat.out_busy) state <= S_IDLE;
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = ebtg_pkg::DIV_GAIN;
    cmd.load      = in_valid && in_ready;
    unique case (state)
      S_STEP_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ebtg_pkg::DIV_STEP;
      end
      S_BEEP_DONE: begin
        cmd.step_wr   = 1'b1;
        cmd.beep_wr   = 1'b1;
      end
      S_MUL1:      cmd.mul1      = 1'b1;
      S_MUL2:      cmd.mul2      = 1'b1;
      S_GAIN_DIV:  cmd.div_start = 1'b1;
      S_TICK_DONE: cmd.tick_wr   = !stat.out_busy;
      default:     ;
    endcase
  end

endmodule

// ----- src/enveloped_beep_tone_generator.sv -----
// Top level of the enveloped beep tone generator: config registers, controller, datapath.
// Depends on ebtg_pkg, ebtg_ctrl, ebtg_datapath.
//
// A sine tone source with linear fade-in and fade-out. A beep beat sets frequency and length
// and gives no result; a tick beat gives one signed 16-bit sample. One beat is in work at a
// time. The phase step and the fade gain share one restoring divider that forms one quotient
// bit per cycle; the tone length comes from a reciprocal multiply that settles while the step
// is divided. A tick passes through dispatch, the two multiplies, divider start, the divider
// steps and done, writeback and the idle state before the next accept; its writeback waits
// while the output register stays full. A beep passes through dispatch, the phase step
// division and writeback. A finished sample sits in the output register while the next beat
// is taken. Registers are to be written only while no beat is in work: the user is bound,
// the block itself does not enforce it.
module enveloped_beep_tone_generator #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32,
  parameter int COUNT_BITS      = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ebtg_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ebtg_pkg::out_t out_data,
  input  logic           write_enable,
  input  logic [1:0]     write_index,
  input  logic [15:0]    write_data
);

  ebtg_pkg::cfg_t     cfg;
  ebtg_pkg::dp_cmd_t  cmd;
  ebtg_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_rate  <= 16'd16000;
      cfg.volume       <= 16'd13107;
      cfg.fade_in_len  <= 12'd256;
      cfg.fade_out_len <= 12'd256;
    end else if (write_enable) begin
      unique case (ebtg_pkg::cfg_idx_t'(write_index))
        ebtg_pkg::CFG_SAMPLE_RATE:  cfg.sample_rate  <= write_data;
        ebtg_pkg::CFG_VOLUME:       cfg.volume       <= write_data;
        ebtg_pkg::CFG_FADE_IN_LEN:  cfg.fade_in_len  <= write_data[11:0];
        ebtg_pkg::CFG_FADE_OUT_LEN: cfg.fade_out_len <= write_data[11:0];
      endcase
    end
  end

  ebtg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ebtg_datapath #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in work");

  a_beep_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.command && !out_valid |=> !out_valid)
    else $error("beep beat produced a result");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a tick in work");

endmodule

// ----- dv/enveloped_beep_tone_generator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for enveloped_beep_tone_generator: directed table, then random phases
// under several register settings, each sample checked against its typed row or tone predictor.
// Depends on ebtg_pkg and enveloped_beep_tone_generator.
module enveloped_beep_tone_generator_tb;

  localparam int TBL_BITS = 10;
  localparam int ACC_BITS = 32;
  localparam int LEN_BITS = 24;
  localparam logic [63:0] QTR_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASE_BEATS = 150;
  localparam int N_PHASES = 12;

  typedef struct packed {
    logic [15:0] rate;
    logic [15:0] vol;
    logic [15:0] fin;
    logic [15:0] fout;
  } tone_setting_t;

  typedef enum logic {ROW_BEAT, ROW_SET} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    ebtg_pkg::in_t  beat;
    bit             typed;
    ebtg_pkg::out_t want;
    tone_setting_t  setting;
  } dir_row_t;

  localparam ebtg_pkg::in_t TICK = '{1'b0, 15'd0, 16'd0};
  localparam ebtg_pkg::out_t SILENT = '{16'sd0, 1'b0};
  localparam ebtg_pkg::out_t HUSH_ON = '{16'sd0, 1'b1};
  localparam tone_setting_t NO_SET = '0;
  localparam tone_setting_t SET_ZERO_RATE = '{16'd0, 16'd65535, 16'hF000, 16'd0};
  localparam tone_setting_t SET_DEFAULT = '{16'd16000, 16'd13107, 16'd256, 16'd256};

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  ebtg_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  ebtg_pkg::out_t out_data;
  logic write_enable;
  logic [1:0] write_index;
  logic [15:0] write_data;

  enveloped_beep_tone_generator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data)
  );

  // predictor state
  logic [15:0] cur_rate = 16'd16000;
  logic [15:0] cur_vol = 16'd13107;
  logic [11:0] cur_fin = 12'd256;
  logic [11:0] cur_fout = 12'd256;
  logic [ACC_BITS-1:0] tone_phase = '0;
  logic [ACC_BITS-1:0] tone_step = '0;
  logic [LEN_BITS-1:0] tone_len = '0;
  logic [LEN_BITS-1:0] tone_pos = '0;
  logic tone_on = 1'b0;

  ebtg_pkg::out_t pending_samples[$];
  int fail_count = 0;
  int n_beats = 0;
  int n_beeps = 0;
  int n_samples = 0;
  int n_active = 0;
  int n_settings = 0;
  bit steady_tx = 1'b0;

  dir_row_t dir_tbl[25];
  tone_setting_t fixed_set[7] = '{
    '{16'd16000, 16'd13107, 16'd256, 16'd256},
    '{16'd8000, 16'd65535, 16'hF001, 16'd1},
    '{16'd48000, 16'd65535, 16'd4095, 16'd4095},
    '{16'd44100, 16'd65535, 16'd0, 16'd0},
    '{16'd65535, 16'd0, 16'd7, 16'd3},
    '{16'd0, 16'd40000, 16'd2, 16'd9},
    '{16'd12000, 16'd32768, 16'hA005, 16'h5004}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(64'd25_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic signed [15:0] sine_q15(input logic [TBL_BITS-1:0] k);
    logic [63:0] span, off, x, x2, t, m;
    span = 64'd1 << (TBL_BITS - 2);
    off = 64'(k[TBL_BITS-3:0]);
    if (k[TBL_BITS-2]) begin
      off = span - off;
    end
    x = (QTR_TURN_Q30 * off) / span;
    x2 = (x * x) >> 30;
    t = UNIT_Q30 - x2 / 64'd72;
    t = UNIT_Q30 - ((x2 * t) >> 30) / 64'd42;
    t = UNIT_Q30 - ((x2 * t) >> 30) / 64'd20;
    t = UNIT_Q30 - ((x2 * t) >> 30) / 64'd6;
    m = (((x * t) >> 30) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return k[TBL_BITS-1] ? -16'(m) : 16'(m);
  endfunction

  // advances the tone state by one beat; returns 1 when the beat yields a sample
  function automatic bit predict_tone_beat(input ebtg_pkg::in_t b, output ebtg_pkg::out_t r);
    logic signed [15:0] s, amp;
    logic [63:0] mag, num, den, rem, len, min_len;
    r = '0;
    if (b.command) begin
      tone_step = (cur_rate != 16'd0) ?
                  32'((64'(b.tone_freq) << ACC_BITS) / 64'(cur_rate)) : '0;
      len = (64'(b.duration_ms) * 64'(cur_rate)) / 64'd1000;
      min_len = 64'(cur_fin) + 64'(cur_fout) + 64'd10;
      if (len < min_len) begin
        len = min_len;
      end
      if (len > 64'((1 << LEN_BITS) - 1)) begin
        len = 64'((1 << LEN_BITS) - 1);
      end
      tone_len = len[LEN_BITS-1:0];
      if (!tone_on) begin
        tone_phase = '0;
        tone_pos = '0;
        tone_on = 1'b1;
      end else begin
        tone_pos = LEN_BITS'(cur_fin);
      end
      return 1'b0;
    end
    amp = '0;
    if (tone_on && tone_pos < tone_len) begin
      s = sine_q15(tone_phase[ACC_BITS-1 -: TBL_BITS]);
      rem = 64'(tone_len - tone_pos);
      num = 64'd1;
      den = 64'd1;
      if (64'(tone_pos) < 64'(cur_fin)) begin
        num = 64'(tone_pos);
        den = 64'(cur_fin);
      end else if (rem < 64'(cur_fout)) begin
        num = rem;
        den = 64'(cur_fout);
      end
      mag = 64'(s[15] ? -s : s);
      mag = (mag * 64'(cur_vol) * num) / (den << 16);
      if (s[15]) begin
        amp = (mag > 64'd32768) ? 16'sh8000 : -16'(mag);
      end else begin
        amp = (mag > 64'd32767) ? 16'sh7fff : 16'(mag);
      end
      tone_phase = tone_phase + tone_step;
      tone_pos = tone_pos + 1'b1;
    end
    if (tone_on && tone_len != '0 && tone_pos >= tone_len) begin
      tone_on = 1'b0;
    end
    r.sample = amp;
    r.active = tone_on;
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic ebtg_pkg::in_t short_beep();
    ebtg_pkg::in_t b;
    b.command = 1'b1;
    b.tone_freq = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 24000));
    b.duration_ms = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 20))
                                                 : 16'($urandom_range(0, 3));
    return b;
  endfunction

  task automatic send_beat(input ebtg_pkg::in_t b, input bit typed, input ebtg_pkg::out_t want);
    int gap;
    ebtg_pkg::out_t got;
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    n_beats++;
    if (b.command) n_beeps++;
    if (predict_tone_beat(b, got)) begin
      pending_samples.push_back(typed ? want : got);
    end
  endtask

  task automatic drain_results();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_samples.size() != 0) begin
      $error("%0d expected samples never arrived", pending_samples.size());
      fail_count++;
      pending_samples.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_tone_regs(input tone_setting_t s);
    drain_results();
    write_enable <= 1'b1;
    write_index <= ebtg_pkg::CFG_SAMPLE_RATE;
    write_data <= s.rate;
    @(posedge clk);
    write_index <= ebtg_pkg::CFG_VOLUME;
    write_data <= s.vol;
    @(posedge clk);
    write_index <= ebtg_pkg::CFG_FADE_IN_LEN;
    write_data <= s.fin;
    @(posedge clk);
    write_index <= ebtg_pkg::CFG_FADE_OUT_LEN;
    write_data <= s.fout;
    @(posedge clk);
    write_enable <= 1'b0;
    cur_rate = s.rate;
    cur_vol = s.vol;
    cur_fin = s.fin[11:0];
    cur_fout = s.fout[11:0];
    n_settings++;
  endtask

  // well-formed beep-then-ticks runs with random content, plus some noise beats
  task automatic run_phase(input int quota);
    int sent, run;
    ebtg_pkg::in_t b;
    sent = 0;
    while (sent < quota) begin
      steady_tx = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 39) == 0) drain_results();
      if ($urandom_range(0, 99) < 80) begin
        send_beat(short_beep(), 1'b0, SILENT);
        sent++;
        run = int'(tone_len - tone_pos) + $urandom_range(0, 3);
        if (run > 60) run = $urandom_range(20, 60);
        for (int k = 0; k < run; k++) begin
          if ($urandom_range(0, 29) == 0) begin
            b = short_beep();
          end else begin
            b = ebtg_pkg::in_t'($urandom);
            b.command = 1'b0;
          end
          send_beat(b, 1'b0, SILENT);
          sent++;
        end
      end else begin
        send_beat(ebtg_pkg::in_t'($urandom), 1'b0, SILENT);
        sent++;
      end
    end
  endtask

  // receiver: random stalls, with stretches of none
  initial begin
    int hold, span;
    bit steady;
    hold = 0;
    span = 0;
    steady = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        span = $urandom_range(50, 300);
      end
      span--;
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : sample_check
    ebtg_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample beat: sample %0d active %0d",
               out_data.sample, out_data.active);
        fail_count++;
      end else begin
        want = pending_samples.pop_front();
        n_samples++;
        if (want.active) n_active++;
        if (out_data.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, out_data.sample);
          fail_count++;
        end
        if (out_data.active !== want.active) begin
          $error("active: expected %0d, got %0d", want.active, out_data.active);
          fail_count++;
        end
      end
    end
  end

  initial begin
    tone_setting_t s;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    write_enable = 1'b0;
    write_index = '0;
    write_data = '0;
    dir_tbl = '{
      '{ROW_BEAT, TICK, 1'b1, SILENT, NO_SET},
      '{ROW_BEAT, '{1'b0, 15'h7fff, 16'hffff}, 1'b1, SILENT, NO_SET},
      // zero rate and zero fades: ten-sample silent tone, then past its end
      '{ROW_SET, TICK, 1'b0, SILENT, SET_ZERO_RATE},
      '{ROW_BEAT, '{1'b1, 15'd1000, 16'hffff}, 1'b0, SILENT, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, SILENT, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, SILENT, NO_SET},
      '{ROW_SET, TICK, 1'b0, SILENT, SET_DEFAULT},
      '{ROW_BEAT, '{1'b1, 15'd1000, 16'd0}, 1'b0, SILENT, NO_SET},
      '{ROW_BEAT, TICK, 1'b1, HUSH_ON, NO_SET},
      '{ROW_BEAT, TICK, 1'b0, SILENT, NO_SET},
      // retriggers: aliased frequency with longest duration, zero frequency, top frequency
      '{ROW_BEAT, '{1'b1, 15'd24000, 16'hffff}, 1'b0, SILENT, NO_SET},
      '{ROW_BEAT, TICK, 1'b0, SILENT, NO_SET},
      '{ROW_BEAT, '{1'b1, 15'd0, 16'd100}, 1'b0, SILENT, NO_SET},
      '{ROW_BEAT, TICK, 1'b0, SILENT, NO_SET},
      '{ROW_BEAT, '{1'b1, 15'h7fff, 16'd1}, 1'b0, SILENT, NO_SET},
      '{ROW_BEAT, TICK, 1'b0, SILENT, NO_SET}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_SET) begin
        program_tone_regs(dir_tbl[i].setting);
      end else begin
        send_beat(dir_tbl[i].beat, dir_tbl[i].typed, dir_tbl[i].want);
      end
    end
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 7) begin
        s = fixed_set[p];
      end else begin
        s.rate = 16'($urandom_range(8000, 48000));
        s.vol = 16'($urandom);
        s.fin = 16'($urandom_range(0, 12));
        s.fout = 16'($urandom_range(0, 12));
      end
      program_tone_regs(s);
      run_phase(PHASE_BEATS);
    end
    drain_results();
    $display("covered %0d beats (%0d beeps) over %0d register settings", n_beats, n_beeps,
             n_settings);
    $display("compared %0d samples, %0d of them inside a tone", n_samples, n_active);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- enveloped_beep_tone_generator.f -----
src/ebtg_pkg.sv
src/ebtg_div.sv
src/ebtg_datapath.sv
src/ebtg_ctrl.sv
src/enveloped_beep_tone_generator.sv
dv/enveloped_beep_tone_generator_tb.sv
